FILE: rtl/abd_pkg.sv
package abd_pkg;

  localparam int SampleW = 16;
  localparam int CoefW   = 15;

  typedef logic signed [SampleW-1:0] q15_t;
  typedef logic [CoefW-1:0]          coef_t;
  typedef logic [1:0]                reg_idx_t;

  // Schmitt trigger thresholds, handed from the top level to the trigger stage
  typedef struct packed {
    coef_t upper;
    coef_t lower;
  } thr_t;

  // register indexes
  localparam reg_idx_t RegLpCoef  = 2'd0;
  localparam reg_idx_t RegRelCoef = 2'd1;
  localparam reg_idx_t RegUpper   = 2'd2;
  localparam reg_idx_t RegLower   = 2'd3;

  // reset values, tuned for 48 kHz
  localparam coef_t LpCoefRst  = 15'd643;
  localparam coef_t RelCoefRst = 15'd32766;
  localparam coef_t UpperRst   = 15'd16384;
  localparam coef_t LowerRst   = 15'd11469;

  localparam coef_t CoefOne = 15'h7FFF;

  function automatic q15_t sat17(input logic signed [SampleW:0] v);
    q15_t res;
    if (v > 17'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[SampleW-1:0];
    end
    return res;
  endfunction

  function automatic q15_t sat_add(input q15_t a, input q15_t b);
    logic signed [SampleW:0] s;
    s = {a[SampleW-1], a} + {b[SampleW-1], b};
    return sat17(s);
  endfunction

  function automatic q15_t sat_sub(input q15_t a, input q15_t b);
    logic signed [SampleW:0] s;
    s = {a[SampleW-1], a} - {b[SampleW-1], b};
    return sat17(s);
  endfunction

  // |a|, with the most negative code clipped to full scale
  function automatic q15_t abs_sat(input q15_t a);
    logic signed [SampleW:0] n;
    n = -{a[SampleW-1], a};
    return a[SampleW-1] ? sat17(n) : a;
  endfunction

endpackage

FILE: rtl/abd_mul.sv
// Shared Q15 multiplier: registered product, read back as
// floor(product / 2^15) clipped to 16 bits.
module abd_mul (
  input  logic          clk,
  input  logic          en,
  input  abd_pkg::coef_t a_i,
  input  abd_pkg::q15_t  b_i,
  output abd_pkg::q15_t  q_o
);

  logic signed [31:0] prod_r;
  logic signed [31:0] prod_nxt;

  assign prod_nxt = $signed({1'b0, a_i}) * b_i;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // arithmetic shift by 15 is a bit-select of the upper 17 bits
  assign q_o = abd_pkg::sat17(prod_r[31:15]);

endmodule

FILE: rtl/abd_trig.sv
// Schmitt trigger on the envelope plus rising-edge detect.
// The previous-trigger bit always equals the stored flag after a step,
// so one flop serves both.
module abd_trig (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          upd_i,
  input  abd_pkg::q15_t env_i,
  input  abd_pkg::thr_t thr_i,
  output logic          pulse_o
);

  logic flag_r;
  logic flag_nxt;

  always_comb begin
    if (!flag_r) begin
      flag_nxt = env_i > $signed({1'b0, thr_i.upper});
    end else begin
      flag_nxt = !(env_i < $signed({1'b0, thr_i.lower}));
    end
  end

  assign pulse_o = flag_nxt & ~flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else if (upd_i) begin
      flag_r <= flag_nxt;
    end
  end

endmodule

FILE: rtl/audio_beat_detector.sv
// channel | handshake             | payload
// in      | in_valid / in_ready   | in_sample (16b signed Q15)
// out     | out_valid / out_ready | out_beat_pulse (1b)
// cfg     | cfg_we                | cfg_index (2b), cfg_data (15b)
//
// A word is taken only in idle. It then steps through MUL1, ADD1, MUL2,
// ADD2 and ENV, on release also REL and SUM, then TRIG, where its result
// word is registered; the next word is taken only once the sequencer is back
// in idle. The single shared 15x16 multiplier serves both filter stages and,
// on release, the two release terms, one product per step.
// in_ready is high only while the sequencer is idle.
// A finished word waits in the output register; the next word may be
// accepted meanwhile and stalls only at its final step.
// Reset (rst_n low, synchronous) clears filter state, envelope and trigger
// and loads the 48 kHz default registers.
module audio_beat_detector (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  abd_pkg::q15_t        in_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_beat_pulse,
  input  logic                 cfg_we,
  input  abd_pkg::reg_idx_t    cfg_index,
  input  abd_pkg::coef_t       cfg_data
);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0; // wait for a sample
  localparam logic [3:0] S_MUL1 = 4'd1; // k * (x - stage1)
  localparam logic [3:0] S_ADD1 = 4'd2; // stage1 += product
  localparam logic [3:0] S_MUL2 = 4'd3; // k * (stage1 - stage2)
  localparam logic [3:0] S_ADD2 = 4'd4; // stage2 += product
  localparam logic [3:0] S_ENV  = 4'd5; // attack, or env * rel
  localparam logic [3:0] S_REL  = 4'd6; // (1 - rel) * level
  localparam logic [3:0] S_SUM  = 4'd7; // env = sum of both terms
  localparam logic [3:0] S_TRIG = 4'd8; // Schmitt + edge, emit word

  logic [3:0] state_r, state_nxt;

  // configuration registers
  abd_pkg::coef_t lp_coef_r, rel_coef_r, upper_r, lower_r;

  // datapath state
  abd_pkg::q15_t x_r, x_nxt;
  abd_pkg::q15_t stage1_r, stage1_nxt;
  abd_pkg::q15_t stage2_r, stage2_nxt;
  abd_pkg::q15_t env_r, env_nxt;
  abd_pkg::q15_t acc_r, acc_nxt;    // first release term
  abd_pkg::q15_t level;             // |stage2|

  logic out_valid_r, out_valid_nxt;
  logic out_pulse_r, out_pulse_nxt;

  // shared multiplier
  logic           mul_en;
  abd_pkg::coef_t mul_a;
  abd_pkg::q15_t  mul_b;
  abd_pkg::q15_t  mul_q;

  logic           trig_upd;
  logic           trig_pulse;
  abd_pkg::thr_t  thr;

  assign thr.upper = upper_r;
  assign thr.lower = lower_r;
  assign level     = abd_pkg::abs_sat(stage2_r);

  abd_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a_i (mul_a),
    .b_i (mul_b),
    .q_o (mul_q)
  );

  abd_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd_i   (trig_upd),
    .env_i   (env_r),
    .thr_i   (thr),
    .pulse_o (trig_pulse)
  );

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    stage1_nxt    = stage1_r;
    stage2_nxt    = stage2_r;
    env_nxt       = env_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_pulse_nxt = out_pulse_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    trig_upd      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_sample;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        mul_en    = 1'b1;
        mul_a     = lp_coef_r;
        mul_b     = abd_pkg::sat_sub(x_r, stage1_r);
        state_nxt = S_ADD1;
      end
      S_ADD1: begin
        stage1_nxt = abd_pkg::sat_add(stage1_r, mul_q);
        state_nxt  = S_MUL2;
      end
      S_MUL2: begin
        mul_en    = 1'b1;
        mul_a     = lp_coef_r;
        mul_b     = abd_pkg::sat_sub(stage1_r, stage2_r);
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        stage2_nxt = abd_pkg::sat_add(stage2_r, mul_q);
        state_nxt  = S_ENV;
      end
      S_ENV: begin
        if (level > env_r) begin
          // instant attack
          env_nxt   = level;
          state_nxt = S_TRIG;
        end else begin
          mul_en    = 1'b1;
          mul_a     = rel_coef_r;
          mul_b     = env_r;
          state_nxt = S_REL;
        end
      end
      S_REL: begin
        acc_nxt   = mul_q;
        mul_en    = 1'b1;
        mul_a     = abd_pkg::CoefOne - rel_coef_r;
        mul_b     = level;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        env_nxt   = abd_pkg::sat_add(acc_r, mul_q);
        state_nxt = S_TRIG;
      end
      S_TRIG: begin
        // hold here while the previous word is still unread
        if (!out_valid_r || out_ready) begin
          trig_upd      = 1'b1;
          out_valid_nxt = 1'b1;
          out_pulse_nxt = trig_pulse;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage1_r    <= '0;
      stage2_r    <= '0;
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage1_r    <= stage1_nxt;
      stage2_r    <= stage2_nxt;
      env_r       <= env_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    acc_r       <= acc_nxt;
    out_pulse_r <= out_pulse_nxt;
  end

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_coef_r  <= abd_pkg::LpCoefRst;
      rel_coef_r <= abd_pkg::RelCoefRst;
      upper_r    <= abd_pkg::UpperRst;
      lower_r    <= abd_pkg::LowerRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abd_pkg::RegLpCoef:  lp_coef_r  <= cfg_data;
        abd_pkg::RegRelCoef: rel_coef_r <= cfg_data;
        abd_pkg::RegUpper:   upper_r    <= cfg_data;
        abd_pkg::RegLower:   lower_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_beat_pulse = out_pulse_r;

endmodule

FILE: rtl/abd_checker.sv
module abd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_beat_pulse
);

  // pulse value of the last word taken
  logic last_pulse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pulse_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_pulse_r <= out_beat_pulse;
    end
  end

  // one word at a time: no accept right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // a word waiting at the output holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat_pulse))
    else $error("output word dropped or changed while stalled");

  // reset leaves an empty, idle block
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // a rising edge cannot repeat on the next word
  a_no_double_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_pulse_r |-> !out_beat_pulse)
    else $error("beat pulse on two words in a row");

endmodule

bind audio_beat_detector abd_checker u_abd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_beat_pulse (out_beat_pulse)
);

FILE: bench/tb_top.sv
module tb_top;
  import abd_pkg::*;

  localparam int ClkHalf   = 5;
  localparam int TailCyc   = 12;
  localparam int CycLimit  = 400000;
  localparam int IdleMax   = 13;
  localparam int HoldCyc   = 200;     // long receiver hold-off

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  q15_t     in_sample = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  logic     out_beat_pulse;
  logic     cfg_we = 1'b0;
  reg_idx_t cfg_index = RegLpCoef;
  coef_t    cfg_data = '0;

  audio_beat_detector dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_beat_pulse (out_beat_pulse),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #ClkHalf clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Beat predictor: its own copy of the registers and the filter state.
  // ---------------------------------------------------------------------
  coef_t lp_k   = LpCoefRst;
  coef_t rel_k  = RelCoefRst;
  coef_t up_thr = UpperRst;
  coef_t lo_thr = LowerRst;

  q15_t lp1 = '0;          // first low-pass stage
  q15_t lp2 = '0;          // second low-pass stage
  q15_t env = '0;          // peak envelope
  logic trig = 1'b0;       // Schmitt trigger flag
  logic trig_d = 1'b0;     // flag of the previous word

  function automatic int clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // Q15 product, floor rounding (arithmetic shift), clipped
  function automatic int q15_mul(input int a, input int b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip16(p >>> 15);
  endfunction

  // advance the predicted state by one sample, return the expected pulse
  function automatic logic beat_of(input q15_t x);
    int f;
    int s;
    int lvl;
    int e;
    logic pulse;
    f = clip16(int'(lp1) + q15_mul(int'(lp_k), clip16(int'(x) - int'(lp1))));
    s = clip16(int'(lp2) + q15_mul(int'(lp_k), clip16(f - int'(lp2))));
    lvl = clip16(s < 0 ? -s : s);   // full-scale negative clips to 32767
    if (lvl > int'(env)) begin
      e = lvl;                       // instant attack
    end else begin
      e = clip16(q15_mul(int'(env), int'(rel_k)) +
                 q15_mul(clip16(32767 - int'(rel_k)), lvl));
    end
    // no ordering assumed between the two thresholds
    if (!trig) begin
      if (e > int'(up_thr)) trig = 1'b1;
    end else begin
      if (e < int'(lo_thr)) trig = 1'b0;
    end
    pulse = trig && !trig_d;
    trig_d = trig;
    lp1 = q15_t'(f);
    lp2 = q15_t'(s);
    env = q15_t'(e);
    return pulse;
  endfunction

  // ---------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------
  typedef struct {
    bit   pause;    // hold the sender until every pulse is back
    q15_t sample;
  } feed_t;

  feed_t feed_q[$];          // words waiting for the driver
  logic  beat_q[$];          // expected pulses, oldest first
  int    n_pushed = 0;       // samples queued by the stimulus
  int    n_sent = 0;         // words accepted by the block
  int    n_got = 0;          // results accepted from the block
  int    n_fail = 0;
  int    in_max = IdleMax;   // sender gap range for this phase
  int    out_max = IdleMax;  // receiver stall range for this phase
  int    cycle_cnt = 0;

  // ---------------------------------------------------------------------
  // Driver: one word at a time from feed_q, random gap after each accept.
  // Prediction happens at the accepting edge.
  // ---------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin
    logic  acc;
    logic  nxt_valid;
    q15_t  nxt_sample;
    feed_t f;
    int    gap;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_sample <= '0;
      gap_left  <= 0;
    end else begin
      acc        = in_valid && in_ready;
      nxt_valid  = in_valid && !acc;
      nxt_sample = in_sample;
      gap        = 0;
      if (acc) begin
        beat_q.push_back(beat_of(in_sample));
        n_sent <= n_sent + 1;
        gap = (in_max == 0) ? 0 : $urandom_range(0, in_max);
      end
      if (!nxt_valid) begin
        if (acc && gap != 0) begin
          gap_left <= gap - 1;
        end else if (!acc && gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (feed_q.size() != 0) begin
          if (feed_q[0].pause) begin
            // pending count as of after this edge
            if (n_sent + int'(acc) == n_got + int'(out_valid && out_ready))
              void'(feed_q.pop_front());
          end else begin
            f          = feed_q.pop_front();
            nxt_valid  = 1'b1;
            nxt_sample = f.sample;
          end
        end
      end
      in_valid  <= nxt_valid;
      in_sample <= nxt_sample;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random stall after each result, plus a long hold-off now and
  // then so the block backs up and drops in_ready.
  // ---------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    logic got;
    logic exp_pulse;
    logic nxt_ready;
    int   draw;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else begin
      got = out_valid && out_ready;
      if (got) begin
        n_got <= n_got + 1;
        if (beat_q.size() == 0) begin
          $error("unexpected result word: beat_pulse=%0b", out_beat_pulse);
          n_fail++;
        end else begin
          exp_pulse = beat_q.pop_front();
          if (out_beat_pulse !== exp_pulse) begin
            $error("beat_pulse mismatch: expected %0b, actual %0b",
                   exp_pulse, out_beat_pulse);
            n_fail++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        nxt_ready = 1'b0;
      end else if (got) begin
        draw = (out_max == 0) ? 0 : $urandom_range(0, out_max);
        if ((n_got + 1) % 400 == 150) begin
          hold_left <= HoldCyc;
          nxt_ready = 1'b0;
        end else if (draw != 0) begin
          stall_left <= draw - 1;
          nxt_ready = 1'b0;
        end else begin
          nxt_ready = 1'b1;
        end
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void push_sample(input q15_t s);
    feed_t f;
    f.pause  = 1'b0;
    f.sample = s;
    feed_q.push_back(f);
    n_pushed++;
  endfunction

  function automatic void push_pause();
    feed_t f;
    f.pause  = 1'b1;
    f.sample = '0;
    feed_q.push_back(f);
  endfunction

  // Random audio: loud DC-ish bursts (they drive the envelope over the
  // threshold), quiet stretches (release) and raw noise (all bit patterns).
  // slow stretches the bursts so the default 150 Hz filter can follow.
  function automatic void fill_audio(input int n, input bit slow);
    int cnt;
    int kind;
    int len;
    int amp;
    int v;
    bit neg;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(0, 19);
      if (kind < 9) begin
        len = slow ? $urandom_range(60, 200) : $urandom_range(3, 30);
        amp = $urandom_range(6000, 32767);
        neg = 1'($urandom_range(0, 1));
        for (int i = 0; i < len && cnt < n; i++) begin
          v = clip16(amp + $urandom_range(0, 4095) - 2048);
          push_sample(q15_t'(neg ? -v - 1 : v));
          cnt++;
        end
      end else if (kind < 16) begin
        len = slow ? $urandom_range(40, 150) : $urandom_range(3, 40);
        for (int i = 0; i < len && cnt < n; i++) begin
          push_sample(q15_t'($urandom_range(0, 1023) - 512));
          cnt++;
        end
      end else begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len && cnt < n; i++) begin
          push_sample(q15_t'($urandom_range(0, 65535)));
          cnt++;
        end
      end
      // one drain-and-wait in the middle of the phase
      if (cnt >= n / 2 && cnt - len < n / 2) push_pause();
    end
  endfunction

  // block until every queued word has come back, then let it settle
  task automatic wait_idle();
    while (n_got != n_pushed) @(posedge clk);
    repeat (TailCyc) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input coef_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      RegLpCoef:  lp_k   = val;
      RegRelCoef: rel_k  = val;
      RegUpper:   up_thr = val;
      RegLower:   lo_thr = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // settle, reprogram all four registers, then pick idle ranges at a
  // falling edge so the driver sees new words cleanly
  task automatic new_phase(input coef_t lp, input coef_t rel, input coef_t up,
                           input coef_t lo, input int imax, input int omax);
    wait_idle();
    write_reg(RegLpCoef, lp);
    write_reg(RegRelCoef, rel);
    write_reg(RegUpper, up);
    write_reg(RegLower, lo);
    @(negedge clk);
    in_max  = imax;
    out_max = omax;
  endtask

  function automatic int pick_idle();
    return ($urandom_range(0, 3) == 0) ? 0 : IdleMax;
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    coef_t up;
    coef_t lo;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults after reset: field extremes and alternating bit patterns
    push_sample(16'sh0000);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh0001);
    push_sample(16'shFFFF);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);

    // full-scale negative drive: second stage reaches -32768, its
    // magnitude must clip to 32767 and still cross the upper threshold
    new_phase(CoefOne, 15'd0, 15'd32766, 15'd0, 0, 0);
    repeat (4) push_sample(16'sh8000);
    repeat (2) push_sample(16'sh0000);

    // upper threshold below lower: flag toggles on every crossing
    new_phase(CoefOne, 15'd16384, 15'd0, CoefOne, 0, IdleMax);
    push_sample(16'sh0000);
    push_sample(16'sh0000);
    push_sample(16'sd200);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh0000);
    push_sample(16'sh0000);
    push_sample(16'sh8000);
    push_sample(16'sh0000);

    // back to the 48 kHz defaults with long bursts
    new_phase(LpCoefRst, RelCoefRst, UpperRst, LowerRst, IdleMax, IdleMax);
    fill_audio(300, 1'b1);

    // frozen filters, slowest release
    new_phase(15'd0, CoefOne, 15'd0, 15'd0, pick_idle(), pick_idle());
    fill_audio(100, 1'b0);

    // all registers at full scale
    new_phase(CoefOne, CoefOne, CoefOne, CoefOne, pick_idle(), pick_idle());
    fill_audio(140, 1'b0);

    // random settings, lower threshold usually under the upper one
    for (int p = 0; p < 6; p++) begin
      up = coef_t'($urandom_range(2000, 30000));
      lo = ($urandom_range(0, 4) == 0) ? coef_t'($urandom_range(0, 32767))
                                       : coef_t'($urandom_range(0, up));
      new_phase(coef_t'($urandom_range(2000, 32767)),
                coef_t'($urandom_range(0, 32767)), up, lo,
                pick_idle(), pick_idle());
      fill_audio(150, 1'b0);
    end

    wait_idle();
    if (beat_q.size() != 0) begin
      $error("%0d expected beat_pulse words never arrived", beat_q.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
